[rtl/dpsp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dpsp_pkg;

    // Largest number of class scores that take part in the argmax.
    localparam int MAX_CLASSES = 64;
    localparam int CNT_W       = $clog2(MAX_CLASSES + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int POSE_WORDS  = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_FY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CX      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DS  = 3'd4;

    // Command codes of an input request.
    localparam logic [1:0] CMD_POSE  = 2'd0;
    localparam logic [1:0] CMD_PIXEL = 2'd1;
    localparam logic [1:0] CMD_SCORE = 2'd2;

    // Pose word that marks a bad frame (-1.0 in Q15.16).
    localparam logic [31:0] BAD_POSE_WORD0 = 32'hFFFF_0000;

    typedef struct packed {
        logic [1:0]         command;
        logic [3:0]         pose_index;
        logic signed [31:0] pose_value;
        logic [11:0]        column;
        logic [11:0]        row;
        logic [15:0]        raw_depth;
        logic signed [15:0] score;
        logic               score_last;
    } t_in;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic [5:0]         class_id;
    } t_out;

    typedef enum logic [1:0] {
        K_POSE,
        K_PIXEL,
        K_SCORE
    } t_kind;

    // Classified request as it travels through the queue.
    typedef struct packed {
        t_kind              kind;
        logic [3:0]         pose_index;
        logic signed [31:0] pose_value;
        logic [11:0]        column;
        logic [11:0]        row;
        logic [15:0]        raw_depth;
        logic signed [15:0] score;
        logic               score_last;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ZD,
        ST_AX,
        ST_AY,
        ST_PX,
        ST_PY,
        ST_MAT
    } t_state;

    // Round to nearest (ties up) and drop 16 fraction bits.
    function automatic logic signed [51:0] rnd16(input logic signed [67:0] v);
        logic signed [67:0] w;
        w = v + 68'sd32768;
        return w[67:16];
    endfunction

    // Saturate to signed 32 bit.
    function automatic logic signed [31:0] sat32(input logic signed [53:0] v);
        if (v > 54'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -54'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

[rtl/dpsp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module dpsp_front import dpsp_pkg::*; (
    input  wire logic  i_valid,
    input  wire t_in   i_data,
    input  wire logic  i_full,
    output logic       o_stall,
    output logic       o_push,
    output t_item      o_item
);

    // Stall only when the queue has no room.
    assign o_stall = i_full;

    // Classify the request; unused commands and out-of-range pose loads are dropped.
    always_comb begin
        o_item.pose_index = i_data.pose_index;
        o_item.pose_value = i_data.pose_value;
        o_item.column     = i_data.column;
        o_item.row        = i_data.row;
        o_item.raw_depth  = i_data.raw_depth;
        o_item.score      = i_data.score;
        o_item.score_last = i_data.score_last;
        o_item.kind       = K_POSE;
        o_push            = 1'b0;
        case (i_data.command)
            CMD_POSE: begin
                o_item.kind = K_POSE;
                o_push      = i_valid && !i_full && (i_data.pose_index < 4'd12);
            end
            CMD_PIXEL: begin
                o_item.kind = K_PIXEL;
                o_push      = i_valid && !i_full;
            end
            CMD_SCORE: begin
                o_item.kind = K_SCORE;
                o_push      = i_valid && !i_full;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/dpsp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module dpsp_queue import dpsp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_item      o_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QPTR_W:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd];

    // Pointer and fill count update.
    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

[rtl/dpsp_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module dpsp_back import dpsp_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_empty,
    input  wire t_item                 i_item,
    output logic                       o_pop,
    output logic                       o_valid,
    output t_out                       o_data,
    input  wire logic                  i_stall
);

    // Configuration registers.
    logic [23:0] r_inv_fx, r_inv_fy, r_inv_ds;
    logic [19:0] r_cx, r_cy;

    // Pose and pixel state.
    logic signed [31:0] r_pose [POSE_WORDS];
    logic signed [31:0] r_held [3];
    logic               r_pending;
    logic               r_supp;
    logic signed [15:0] r_best;
    logic [5:0]         r_class;
    logic [CNT_W-1:0]   r_count;

    // Projection datapath.
    t_state             r_state, n_state;
    logic [11:0]        r_u, r_v;
    logic signed [67:0] r_prod;
    logic signed [33:0] r_z, r_ax, r_ay;
    logic signed [31:0] r_p [3];
    logic signed [53:0] r_acc;
    logic [1:0]         r_row, r_col;
    logic [1:0]         n_row, n_col;

    logic               r_out_valid;
    t_out               r_out;

    logic               bad_pose;
    logic               take;
    logic               take_score;
    logic               take_pixel;
    logic               start_mul;
    logic signed [33:0] op_a, op_b;
    logic signed [33:0] dx, dy;
    logic signed [53:0] prod_r16;
    logic signed [53:0] acc_n;
    logic [3:0]         pidx;
    logic               last_mat;

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // A frame whose pose is minus identity on word zero only is marked bad.
    always_comb begin
        bad_pose = (r_pose[0] == BAD_POSE_WORD0);
        for (int i = 1; i < POSE_WORDS; i++) begin
            if (r_pose[i] != '0) begin
                bad_pose = 1'b0;
            end
        end
    end

    // Pull the next request when idle; a score waits for a free output register.
    always_comb begin
        take = (r_state == ST_IDLE) && !i_empty &&
               ((i_item.kind != K_SCORE) || !r_out_valid || !i_stall);
        take_score = take && (i_item.kind == K_SCORE);
        take_pixel = take && (i_item.kind == K_PIXEL);
        o_pop      = take;
        start_mul  = take_pixel && (i_item.raw_depth != '0) && !bad_pose;
    end

    assign dx       = $signed({14'd0, r_u, 8'd0}) - $signed({14'd0, r_cx});
    assign dy       = $signed({14'd0, r_v, 8'd0}) - $signed({14'd0, r_cy});
    assign prod_r16 = 54'(rnd16(r_prod));
    assign last_mat = (r_row == 2'd2) && (r_col == 2'd2);

    // Next matrix element after the one now in the product register.
    always_comb begin
        if (r_state != ST_MAT) begin
            n_row = 2'd0;
            n_col = 2'd0;
        end else if (r_col == 2'd2) begin
            n_row = r_row + 2'd1;
            n_col = 2'd0;
        end else begin
            n_row = r_row;
            n_col = r_col + 2'd1;
        end
        pidx = {n_row, 2'b00} + {2'b00, n_col};
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (start_mul) n_state = ST_ZD;
            ST_ZD:   n_state = ST_AX;
            ST_AX:   n_state = ST_AY;
            ST_AY:   n_state = ST_PX;
            ST_PX:   n_state = ST_PY;
            ST_PY:   n_state = ST_MAT;
            ST_MAT:  if (last_mat) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Operands of the shared multiplier for each step.
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_state)
            ST_IDLE: begin
                op_a = $signed({18'd0, i_item.raw_depth});
                op_b = $signed({10'd0, r_inv_ds});
            end
            ST_ZD: begin
                op_a = dx;
                op_b = $signed({10'd0, r_inv_fx});
            end
            ST_AX: begin
                op_a = dy;
                op_b = $signed({10'd0, r_inv_fy});
            end
            ST_AY: begin
                op_a = r_ax;
                op_b = r_z;
            end
            ST_PX: begin
                op_a = r_ay;
                op_b = r_z;
            end
            ST_PY, ST_MAT: begin
                op_a = 34'(r_pose[pidx]);
                op_b = 34'(r_p[n_col]);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Running row sum: translation plus the rounded rotation products.
    always_comb begin
        if (r_col == 2'd0) begin
            acc_n = 54'(r_pose[{r_row, 2'b11}]) + prod_r16;
        end else begin
            acc_n = r_acc + prod_r16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Multiplier and projection datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
        if (take_pixel) begin
            r_u <= i_item.column;
            r_v <= i_item.row;
        end
        case (r_state)
            ST_ZD: r_z  <= 34'((r_prod + 68'sd128) >>> 8);
            ST_AX: r_ax <= 34'(rnd16(r_prod));
            ST_AY: r_ay <= 34'(rnd16(r_prod));
            ST_PX: r_p[0] <= sat32(prod_r16);
            ST_PY: begin
                r_p[1] <= sat32(prod_r16);
                r_p[2] <= sat32(54'(r_z));
            end
            ST_MAT: r_acc <= acc_n;
            default: ;
        endcase
        r_row <= n_row;
        r_col <= n_col;
    end

    // Configuration and pose words; pixel bookkeeping and argmax.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_fx  <= 24'd45788;
            r_inv_fy  <= 24'd45788;
            r_cx      <= 20'd64372;
            r_cy      <= 20'd52632;
            r_inv_ds  <= 24'd16777;
            for (int i = 0; i < POSE_WORDS; i++) begin
                r_pose[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_held[i] <= '0;
            end
            r_pending <= 1'b0;
            r_supp    <= 1'b0;
            r_best    <= '0;
            r_class   <= '0;
            r_count   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INV_FX: r_inv_fx <= i_cfg_data;
                    CFG_INV_FY: r_inv_fy <= i_cfg_data;
                    CFG_CX:     r_cx     <= i_cfg_data[19:0];
                    CFG_CY:     r_cy     <= i_cfg_data[19:0];
                    CFG_INV_DS: r_inv_ds <= i_cfg_data;
                    default: ;
                endcase
            end
            if (take && (i_item.kind == K_POSE)) begin
                r_pose[i_item.pose_index] <= i_item.pose_value;
            end
            if (take_pixel) begin
                r_pending <= 1'b1;
                r_supp    <= (i_item.raw_depth == '0) || bad_pose;
                r_best    <= '0;
                r_class   <= '0;
                r_count   <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_held[i] <= '0;
                end
            end
            if (r_state == ST_MAT && r_col == 2'd2) begin
                r_held[r_row] <= sat32((r_row == 2'd0) ? acc_n : -acc_n);
            end
            if (take_score && r_pending) begin
                if (r_count < CNT_W'(MAX_CLASSES)) begin
                    if (r_count == '0 || i_item.score > r_best) begin
                        r_best  <= i_item.score;
                        r_class <= 6'(r_count);
                    end
                    r_count <= r_count + 1'b1;
                end
                if (i_item.score_last) begin
                    r_pending <= 1'b0;
                end
            end
        end
    end

    // Output register: loaded by the final score of an unsuppressed pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take_score && r_pending && i_item.score_last && !r_supp) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_score && r_pending && i_item.score_last && !r_supp) begin
            r_out.world_x <= r_held[0];
            r_out.world_y <= r_held[1];
            r_out.world_z <= r_held[2];
            if (r_count < CNT_W'(MAX_CLASSES) &&
                (r_count == '0 || i_item.score > r_best)) begin
                r_out.class_id <= 6'(r_count);
            end else begin
                r_out.class_id <= r_class;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/depth_pixel_semantic_point_projector.sv]
`timescale 1ns / 1ps
`default_nettype none

// Depth pixel to world point projector with semantic class selection.
// Input channel (i_in_valid, i_in_data, o_in_stall) carries pose loads,
// pixel geometry and class scores; output channel (o_out_valid, o_out_data,
// i_out_stall) carries one world point plus class index per unsuppressed pixel.
// Requests enter a four-entry queue; the back end takes one request at a time.
// A pixel with zero depth or under a bad pose is suppressed and gives no
// output. Otherwise the back end computes z, x and y and then nine rotation
// products on one shared 34x34 multiplier, and takes no further request
// until the pixel is done. The last score passes through the queue and then
// loads the output register that drives o_out_valid. Configuration writes
// (i_cfg_we) load the camera registers directly, not through the queue.
// A synchronous low i_rst_n clears the queue, the pose, the pending pixel and
// the output register, and loads the default camera registers.
// When the receiver stalls, the result holds in the output register; the
// next score waits in the queue and the input stalls once it is full.

module depth_pixel_semantic_point_projector import dpsp_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire t_in                   i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output t_out                       o_out_data,
    input  wire logic                  i_out_stall
);

    logic  push, pop, full, empty;
    t_item push_item, head_item;

    dpsp_front u_front (
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_full  (full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_item  (push_item)
    );

    dpsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (head_item)
    );

    dpsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_empty     (empty),
        .i_item      (head_item),
        .o_pop       (pop),
        .o_valid     (o_out_valid),
        .o_data      (o_out_data),
        .i_stall     (i_out_stall)
    );

endmodule

`default_nettype wire

[rtl/dpsp_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module dpsp_chk import dpsp_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_in_stall,
    input wire logic o_out_valid,
    input wire logic i_out_stall
);

    // A waiting result is not withdrawn while the receiver stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped under stall");

    // Reset empties the output register.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Reset empties the queue, so the input is open right after it.
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind depth_pixel_semantic_point_projector dpsp_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall)
);

`default_nettype wire
